// ===== design/gff_pkg.sv =====
// shared types and constants for the grid flood fill block
`timescale 1ns / 1ps

package gff_pkg;

   // command codes of the request word
   localparam logic [1:0] CMD_WALL  = 2'd0;
   localparam logic [1:0] CMD_FILL  = 2'd1;
   localparam logic [1:0] CMD_QUERY = 2'd2;

   // value of a wall bit that blocks the walk
   localparam logic ID_WALL = 1'b1;

   // one entry of the cell memory
   typedef struct packed {
      logic wall;
      logic visited;
   } cell_bits_type;

   // write request to the cell memory, one enable per bit
   typedef struct packed {
      logic          wall_en;
      logic          visited_en;
      cell_bits_type data;
   } cell_wr_type;

endpackage

// ===== design/grid_flood_fill_reachability.sv =====
// top level of the 4-connected grid flood fill with reachability queries
`timescale 1ns / 1ps

// usage
//   request channel (req_valid / req_stall) carries one command word:
//     write wall bit: stores req_wall for the addressed cell
//     fill: clears the visited map, then walks from the addressed cell
//     query: returns one rsp word with rsp_reached for the addressed cell
//   result channel (rsp_valid / rsp_stall) carries query answers only
// handshake and order of work
//   wall write: written on acceptance, the next word can follow at once
//   query: rsp_valid rises after the cell memory read, then the output
//     register; no new word is taken until the answer is registered
//   fill: a visited clear over all 2**(clog2(cols)+clog2(rows)) cell
//     addresses (512 for 32 x 16) and a seed read and check, then per reached
//     cell a pop, four neighbor reads on the cell memory read port and a last
//     check; no new word is taken until the walk ends
// reset
//   a clearing pass over every cell address wipes walls and visited bits;
//   req_stall stays high until it ends
// stall
//   while a result waits under rsp_stall, no new request word is taken

module grid_flood_fill_reachability
   import gff_pkg::*;
#(
   parameter int GRID_COLS = 32,
   parameter int GRID_ROWS = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_command,
   input  logic [4:0] req_col,
   input  logic [3:0] req_row,
   input  logic       req_wall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_reached
);

   // cell address is {row, col}, each field $clog2 of its grid size wide
   localparam int CW = $clog2(GRID_COLS);
   localparam int RW = $clog2(GRID_ROWS);
   localparam int AW = CW + RW;

   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_reached_ff, rsp_reached_in;
   logic          rsp_free;
   logic          hit_valid;
   logic          hit;

   logic [AW-1:0] cm_waddr;
   cell_wr_type   cm_wr;
   logic [AW-1:0] cm_raddr;
   cell_bits_type cm_rdata;

   logic          st_we;
   logic [AW-1:0] st_waddr;
   logic [AW-1:0] st_wdata;
   logic [AW-1:0] st_raddr;
   logic [AW-1:0] st_rdata;

   // output slot is free at the next edge if empty or taken now
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   gff_seq #(
      .GRID_COLS (GRID_COLS),
      .GRID_ROWS (GRID_ROWS),
      .CW        (CW),
      .RW        (RW),
      .AW        (AW)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_command (req_command),
      .req_col     (req_col),
      .req_row     (req_row),
      .req_wall    (req_wall),
      .rsp_free    (rsp_free),
      .hit_valid   (hit_valid),
      .hit         (hit),
      .cm_waddr    (cm_waddr),
      .cm_wr       (cm_wr),
      .cm_raddr    (cm_raddr),
      .cm_rdata    (cm_rdata),
      .st_we       (st_we),
      .st_waddr    (st_waddr),
      .st_wdata    (st_wdata),
      .st_raddr    (st_raddr),
      .st_rdata    (st_rdata)
   );

   // wall and visited bits per cell
   gff_cell_mem #(
      .AW (AW)
   ) u_cell_mem (
      .clock   (clock),
      .wr_addr (cm_waddr),
      .wr      (cm_wr),
      .rd_addr (cm_raddr),
      .rd_data (cm_rdata)
   );

   // cells waiting for their neighbors to be checked
   gff_stack_mem #(
      .AW (AW)
   ) u_stack_mem (
      .clock   (clock),
      .wr_en   (st_we),
      .wr_addr (st_waddr),
      .wr_data (st_wdata),
      .rd_addr (st_raddr),
      .rd_data (st_rdata)
   );

   // output register: a query answer lands here in the cycle after the memory read
   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_reached_in = rsp_reached_ff;
      if (hit_valid) begin
         rsp_valid_in   = 1'b1;
         rsp_reached_in = hit;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      rsp_reached_ff <= rsp_reached_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_reached = rsp_reached_ff;

endmodule

// ===== design/gff_cell_mem.sv =====
// cell memory: wall and visited bits per cell, bit write enables, registered read
`timescale 1ns / 1ps

module gff_cell_mem
   import gff_pkg::*;
#(
   parameter int AW = 9
) (
   input  logic          clock,
   input  logic [AW-1:0] wr_addr,
   input  cell_wr_type   wr,
   input  logic [AW-1:0] rd_addr,
   output cell_bits_type rd_data
);

   cell_bits_type mem [2**AW];

   always_ff @(posedge clock) begin
      if (wr.wall_en) begin
         mem[wr_addr].wall <= wr.data.wall;
      end
      if (wr.visited_en) begin
         mem[wr_addr].visited <= wr.data.visited;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== design/gff_stack_mem.sv =====
// walk stack memory: one write port, one registered read port
`timescale 1ns / 1ps

module gff_stack_mem #(
   parameter int AW = 9
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [AW-1:0] wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [AW-1:0] rd_data
);

   logic [AW-1:0] mem [2**AW];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== design/gff_seq.sv =====
// command sequencer: wall writes, queries, clearing pass and stack-based fill walk
`timescale 1ns / 1ps

module gff_seq
   import gff_pkg::*;
#(
   parameter int GRID_COLS = 32,
   parameter int GRID_ROWS = 16,
   parameter int CW = 5,
   parameter int RW = 4,
   parameter int AW = 9
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  logic [1:0]    req_command,
   input  logic [4:0]    req_col,
   input  logic [3:0]    req_row,
   input  logic          req_wall,
   input  logic          rsp_free,
   output logic          hit_valid,
   output logic          hit,
   output logic [AW-1:0] cm_waddr,
   output cell_wr_type   cm_wr,
   output logic [AW-1:0] cm_raddr,
   input  cell_bits_type cm_rdata,
   output logic          st_we,
   output logic [AW-1:0] st_waddr,
   output logic [AW-1:0] st_wdata,
   output logic [AW-1:0] st_raddr,
   input  logic [AW-1:0] st_rdata
);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SEED,
      S_POP,
      S_NBR,
      S_EVAL
   } state_type;

   typedef enum logic [1:0] {
      DIR_RIGHT,
      DIR_LEFT,
      DIR_DOWN,
      DIR_UP
   } dir_type;

   state_type     state_ff, state_in;
   dir_type       dir_ff, dir_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic          clr_wall_ff, clr_wall_in;
   logic [AW:0]   depth_ff, depth_in;
   logic          pend_ff, pend_in;
   logic [AW-1:0] pend_addr_ff, pend_addr_in;
   logic [AW-1:0] cur_ff, cur_in;
   logic [AW-1:0] start_ff, start_in;
   logic          start_ok_ff, start_ok_in;
   logic          q_pend_ff, q_pend_in;
   logic          q_ok_ff, q_ok_in;

   logic          accept;
   logic          req_in_grid;
   logic [AW-1:0] req_addr;
   logic [AW-1:0] cur_pos;
   logic [CW-1:0] cur_col;
   logic [RW-1:0] cur_row;
   logic          nbr_ok;
   logic [AW-1:0] nbr_addr;
   logic          push;

   assign req_stall   = (state_ff != S_IDLE) || q_pend_ff || !rsp_free;
   assign accept      = req_valid && !req_stall;
   assign req_in_grid = (32'(req_col) < GRID_COLS) && (32'(req_row) < GRID_ROWS);
   assign req_addr    = {RW'(req_row), CW'(req_col)};

   assign hit_valid = q_pend_ff;
   assign hit       = q_ok_ff && cm_rdata.visited;

   // popped cell arrives from the stack read in the first neighbor cycle
   assign cur_pos = (dir_ff == DIR_RIGHT) ? st_rdata : cur_ff;
   assign cur_col = cur_pos[CW-1:0];
   assign cur_row = cur_pos[AW-1:CW];

   always_comb begin
      unique case (dir_ff)
         DIR_RIGHT: begin
            nbr_ok   = (32'(cur_col) + 32'd1) < GRID_COLS;
            nbr_addr = {cur_row, CW'(cur_col + 1'b1)};
         end
         DIR_LEFT: begin
            nbr_ok   = cur_col != '0;
            nbr_addr = {cur_row, CW'(cur_col - 1'b1)};
         end
         DIR_DOWN: begin
            nbr_ok   = (32'(cur_row) + 32'd1) < GRID_ROWS;
            nbr_addr = {RW'(cur_row + 1'b1), cur_col};
         end
         DIR_UP: begin
            nbr_ok   = cur_row != '0;
            nbr_addr = {RW'(cur_row - 1'b1), cur_col};
         end
         default: begin
            nbr_ok   = 1'b0;
            nbr_addr = '0;
         end
      endcase
   end

   // candidate read last cycle is open and unmarked
   assign push = pend_ff && (cm_rdata.wall != ID_WALL) && !cm_rdata.visited;

   always_comb begin
      state_in     = state_ff;
      dir_in       = dir_ff;
      clr_in       = clr_ff;
      clr_wall_in  = clr_wall_ff;
      depth_in     = depth_ff;
      pend_in      = 1'b0;
      pend_addr_in = pend_addr_ff;
      cur_in       = cur_ff;
      start_in     = start_ff;
      start_ok_in  = start_ok_ff;
      q_pend_in    = 1'b0;
      q_ok_in      = q_ok_ff;
      cm_waddr     = pend_addr_ff;
      cm_wr        = '0;
      cm_raddr     = nbr_addr;
      st_we        = 1'b0;
      st_waddr     = depth_ff[AW-1:0];
      st_wdata     = pend_addr_ff;
      st_raddr     = AW'(depth_ff - 1'b1);

      if ((state_ff == S_NBR || state_ff == S_EVAL) && push) begin
         cm_wr.visited_en   = 1'b1;
         cm_wr.data.visited = 1'b1;
         st_we              = 1'b1;
         depth_in           = depth_ff + 1'b1;
      end

      unique case (state_ff)
         S_CLEAR: begin
            cm_waddr   = clr_ff;
            cm_wr      = '0;
            cm_wr.visited_en = 1'b1;
            cm_wr.wall_en    = clr_wall_ff;
            clr_in     = clr_ff + 1'b1;
            if (clr_ff == '1) begin
               clr_wall_in = 1'b0;
               state_in    = clr_wall_ff ? S_IDLE : S_SEED;
            end
         end
         S_IDLE: begin
            cm_raddr = req_addr;
            if (accept) begin
               unique case (req_command)
                  CMD_WALL: begin
                     cm_waddr         = req_addr;
                     cm_wr.wall_en    = req_in_grid;
                     cm_wr.data.wall  = req_wall;
                  end
                  CMD_FILL: begin
                     start_in    = req_addr;
                     start_ok_in = req_in_grid;
                     clr_in      = '0;
                     state_in    = S_CLEAR;
                  end
                  CMD_QUERY: begin
                     q_pend_in = 1'b1;
                     q_ok_in   = req_in_grid;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SEED: begin
            cm_raddr     = start_ff;
            pend_in      = start_ok_ff;
            pend_addr_in = start_ff;
            state_in     = S_EVAL;
         end
         S_POP: begin
            if (depth_ff == '0) begin
               state_in = S_IDLE;
            end else begin
               depth_in = depth_ff - 1'b1;
               dir_in   = DIR_RIGHT;
               state_in = S_NBR;
            end
         end
         S_NBR: begin
            cur_in       = cur_pos;
            pend_in      = nbr_ok;
            pend_addr_in = nbr_addr;
            dir_in       = dir_type'(dir_ff + 1'b1);
            if (dir_ff == DIR_UP) begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            state_in = S_POP;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      pend_addr_ff <= pend_addr_in;
      cur_ff       <= cur_in;
      start_ff     <= start_in;
      start_ok_ff  <= start_ok_in;
      q_ok_ff      <= q_ok_in;
      if (reset) begin
         state_ff    <= S_CLEAR;
         dir_ff      <= DIR_RIGHT;
         clr_ff      <= '0;
         clr_wall_ff <= 1'b1;
         depth_ff    <= '0;
         pend_ff     <= 1'b0;
         q_pend_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         dir_ff      <= dir_in;
         clr_ff      <= clr_in;
         clr_wall_ff <= clr_wall_in;
         depth_ff    <= depth_in;
         pend_ff     <= pend_in;
         q_pend_ff   <= q_pend_in;
      end
   end

`ifndef SYNTHESIS
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      st_we |-> !depth_ff[AW])
      else $error("stack push with stack full");

   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (depth_ff == '0))
      else $error("stack not empty when idle");

   a_query_result: assert property (@(posedge clock) disable iff (reset)
      (accept && req_command == CMD_QUERY) |=> hit_valid)
      else $error("query result missing");

   a_mark_hazard: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_NBR && cm_wr.visited_en) |-> (cm_waddr != cm_raddr))
      else $error("mark and read of the same cell in one cycle");
`endif

endmodule

// ===== tb/gff_reach_checker.sv =====
// checker for the grid flood fill block: predicts query answers and compares them
`timescale 1ns / 1ps

module gff_reach_checker
   import gff_pkg::*;
#(
   parameter int GRID_COLS = 32,
   parameter int GRID_ROWS = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [1:0] req_command,
   input  logic [4:0] req_col,
   input  logic [3:0] req_row,
   input  logic       req_wall,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic       rsp_reached,
   output int         mismatch_count,
   output int         answers_due
);

   localparam int CELLS = GRID_COLS * GRID_ROWS;

   typedef struct packed {
      logic [4:0] col;
      logic [3:0] row;
      logic       reached;
   } reach_answer_type;

   logic             wall_bits [CELLS];
   logic             reach_bits [CELLS];
   int               open_cells [CELLS];
   int               open_count;
   reach_answer_type answer_q [$];

   function automatic bit on_grid(int c, int r);
      return c >= 0 && c < GRID_COLS && r >= 0 && r < GRID_ROWS;
   endfunction

   // mark an open, unmarked cell and put it on the walk list
   function automatic void mark_cell(int c, int r);
      int idx;
      if (!on_grid(c, r))
         return;
      idx = r * GRID_COLS + c;
      if (wall_bits[idx] == ID_WALL || reach_bits[idx])
         return;
      reach_bits[idx] = 1'b1;
      open_cells[open_count] = idx;
      open_count++;
   endfunction

   function automatic void flood_from(int c, int r);
      int idx;
      int pc;
      int pr;
      foreach (reach_bits[i])
         reach_bits[i] = 1'b0;
      open_count = 0;
      mark_cell(c, r);
      while (open_count > 0) begin
         open_count--;
         idx = open_cells[open_count];
         pc = idx % GRID_COLS;
         pr = idx / GRID_COLS;
         mark_cell(pc + 1, pr);
         mark_cell(pc - 1, pr);
         mark_cell(pc, pr + 1);
         mark_cell(pc, pr - 1);
      end
   endfunction

   always @(posedge clock) begin
      reach_answer_type want;
      reach_answer_type got;
      if (reset) begin
         foreach (wall_bits[i]) begin
            wall_bits[i] = 1'b0;
            reach_bits[i] = 1'b0;
         end
         answer_q.delete();
         mismatch_count = 0;
      end else begin
         // result side first: a word leaving now belongs to an earlier query
         if (rsp_valid && !rsp_stall) begin
            if (answer_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t ns: result word with no query pending, reached %b",
                           $time, rsp_reached);
            end else begin
               want = answer_q.pop_front();
               got = want;
               got.reached = rsp_reached;
               if (got.reached !== want.reached) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("%0t ns: reached at col %0d row %0d: expected %b got %b",
                              $time, want.col, want.row, want.reached, got.reached);
               end
            end
         end
         if (req_valid && !req_stall) begin
            case (req_command)
               CMD_WALL: begin
                  if (on_grid(int'(req_col), int'(req_row)))
                     wall_bits[int'(req_row) * GRID_COLS + int'(req_col)] = req_wall;
               end
               CMD_FILL: flood_from(int'(req_col), int'(req_row));
               CMD_QUERY: begin
                  want.col = req_col;
                  want.row = req_row;
                  want.reached = 1'b0;
                  if (on_grid(int'(req_col), int'(req_row)))
                     want.reached = reach_bits[int'(req_row) * GRID_COLS + int'(req_col)];
                  answer_q.push_back(want);
               end
               default: ;
            endcase
         end
      end
      answers_due = answer_q.size();
   end

endmodule

// ===== tb/grid_flood_fill_reachability_test.sv =====
// testbench top for the grid flood fill block: stimulus, handshake pressure and verdict
`timescale 1ns / 1ps

module grid_flood_fill_reachability_test;
   import gff_pkg::*;

   localparam int COLS = 32;
   localparam int ROWS = 16;
   // command code the block must drop
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   // words (ignored command 3 excluded) to send before stopping
   localparam int WORD_TARGET = 290;
   // from here on neither side idles
   localparam int QUIET_FROM = 250;
   // one full fill: visited clear plus the walk over every cell, with margin
   localparam int DRAIN_CYCLES = 4200;
   localparam int CYCLE_LIMIT = 1000000;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [1:0] req_command = CMD_WALL;
   logic [4:0] req_col = '0;
   logic [3:0] req_row = '0;
   logic       req_wall = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_reached;

   int         mismatch_count;
   int         answers_due;
   int         words_sent = 0;
   int         cycle_count = 0;
   logic       quiet_tail = 1'b0;

   // 4 ns period
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   grid_flood_fill_reachability u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_command (req_command),
      .req_col     (req_col),
      .req_row     (req_row),
      .req_wall    (req_wall),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_reached (rsp_reached)
   );

   gff_reach_checker #(
      .GRID_COLS (COLS),
      .GRID_ROWS (ROWS)
   ) u_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_command    (req_command),
      .req_col        (req_col),
      .req_row        (req_row),
      .req_wall       (req_wall),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_reached    (rsp_reached),
      .mismatch_count (mismatch_count),
      .answers_due    (answers_due)
   );

   // watchdog against a hung fill or a lost handshake
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("grid_flood_fill_reachability_test NOT OK");
         $finish;
      end
   end

   // result side back-pressure: random stall bursts, none in the quiet tail
   initial begin
      forever begin
         @(posedge clock);
         if (!quiet_tail && $urandom_range(0, 11) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 15)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // present one word and hold it until the block takes it
   // called and returns on a rising edge
   task automatic send_word(input logic [1:0] cmd, input int col, input int row,
                            input logic wall);
      int gap;
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 15);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_command <= cmd;
      req_col     <= col[4:0];
      req_row     <= row[3:0];
      req_wall    <= wall;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      if (cmd != CMD_UNUSED)
         words_sent++;
      if (words_sent >= QUIET_FROM)
         quiet_tail = 1'b1;
   endtask

   initial begin
      int n;
      int k;
      int c;
      int r;
      int sc;
      int sr;
      int lc;
      int lr;
      int pick;
      logic horiz;
      logic w;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // --- directed part ---
      // nothing filled yet: every query answers zero
      send_word(CMD_QUERY, 0, 0, 1'b0);
      // unused command with every field bit set, must be dropped
      send_word(CMD_UNUSED, 31, 15, 1'b1);
      // wall off the top-left corner cell
      send_word(CMD_WALL, 1, 0, ID_WALL);
      send_word(CMD_WALL, 0, 1, ID_WALL);
      // fill inside the pocket: only the corner itself is marked
      send_word(CMD_FILL, 0, 0, 1'b1);
      send_word(CMD_QUERY, 0, 0, 1'b0);
      send_word(CMD_QUERY, 1, 0, 1'b1);
      send_word(CMD_QUERY, 31, 15, 1'b0);
      // fill from the far corner: everything but the pocket and its walls
      send_word(CMD_FILL, 31, 15, 1'b0);
      send_word(CMD_QUERY, 0, 0, 1'b0);
      send_word(CMD_QUERY, 31, 15, 1'b0);
      send_word(CMD_QUERY, 0, 1, 1'b0);
      // wall field is don't-care on a query
      send_word(CMD_QUERY, 5, 7, 1'b1);
      // fill starting on a wall marks nothing
      send_word(CMD_FILL, 1, 0, 1'b0);
      send_word(CMD_QUERY, 31, 15, 1'b0);
      // a wall written after a fill leaves the visited map alone
      send_word(CMD_FILL, 31, 15, 1'b1);
      send_word(CMD_WALL, 31, 15, ID_WALL);
      send_word(CMD_QUERY, 31, 15, 1'b0);
      // open the pocket again, all but the wall at col 0 row 1 reachable from the origin
      send_word(CMD_WALL, 31, 15, ~ID_WALL);
      send_word(CMD_WALL, 1, 0, ~ID_WALL);
      send_word(CMD_FILL, 0, 0, 1'b0);
      send_word(CMD_QUERY, 31, 15, 1'b0);
      send_word(CMD_QUERY, 0, 1, 1'b0);

      // --- random rounds: wall edits, one fill, a burst of queries ---
      lc = 0;
      lr = 0;
      while (words_sent < WORD_TARGET) begin
         n = $urandom_range(2, 16);
         c = $urandom_range(0, COLS - 1);
         r = $urandom_range(0, ROWS - 1);
         // mostly raise walls, sometimes knock a line down
         w = ($urandom_range(0, 4) != 0) ? ID_WALL : ~ID_WALL;
         if ($urandom_range(0, 2) != 0) begin
            // straight segment, which is what splits the grid into regions
            horiz = 1'($urandom_range(0, 1));
            for (k = 0; k < n; k++) begin
               lc = horiz ? (c + k) % COLS : c;
               lr = horiz ? r : (r + k) % ROWS;
               send_word(CMD_WALL, lc, lr, w);
            end
         end else begin
            for (k = 0; k < n; k++) begin
               lc = $urandom_range(0, COLS - 1);
               lr = $urandom_range(0, ROWS - 1);
               send_word(CMD_WALL, lc, lr, $urandom_range(0, 3) != 0);
            end
         end
         if ($urandom_range(0, 5) == 0)
            send_word(CMD_UNUSED, $urandom_range(0, COLS - 1), $urandom_range(0, ROWS - 1),
                      1'($urandom_range(0, 1)));

         // start cell: now and then the last edited cell, often a wall
         if ($urandom_range(0, 5) == 0) begin
            sc = lc;
            sr = lr;
         end else begin
            sc = $urandom_range(0, COLS - 1);
            sr = $urandom_range(0, ROWS - 1);
         end
         send_word(CMD_FILL, sc, sr, 1'($urandom_range(0, 1)));

         n = $urandom_range(2, 10);
         for (k = 0; k < n; k++) begin
            pick = $urandom_range(0, 5);
            if (pick < 3) begin
               // around the start cell, where the answer flips most
               c = (sc + COLS + $urandom_range(0, 8) - 4) % COLS;
               r = (sr + ROWS + $urandom_range(0, 4) - 2) % ROWS;
            end else if (pick == 3) begin
               // next to the last wall edit
               c = (lc + COLS + $urandom_range(0, 2) - 1) % COLS;
               r = (lr + ROWS + $urandom_range(0, 2) - 1) % ROWS;
            end else begin
               c = $urandom_range(0, COLS - 1);
               r = $urandom_range(0, ROWS - 1);
            end
            send_word(CMD_QUERY, c, r, 1'($urandom_range(0, 1)));
            // stray wall edit between queries, must not disturb the answers
            if ($urandom_range(0, 7) == 0)
               send_word(CMD_WALL, $urandom_range(0, COLS - 1), $urandom_range(0, ROWS - 1),
                         1'($urandom_range(0, 1)));
         end
      end
      req_valid <= 1'b0;

      // let every query answer come back, then cover a trailing fill
      while (answers_due != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && answers_due == 0)
         $display("grid_flood_fill_reachability_test OK");
      else
         $display("grid_flood_fill_reachability_test NOT OK");
      $finish;
   end

endmodule
